### src/trial_division_prime_test_assert.svh
// Assertion macros used by the checker file.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tdpt_pkg.sv
package tdpt_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

### src/tdpt_rem_unit.sv
module tdpt_rem_unit import tdpt_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output rem_stat_t              stat
);

	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			cnt_q <= CW'(VALUE_WIDTH);
		end else if (busy_q) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

### src/trial_division_prime_test.sv
// Channel | Handshake           | Payload
// in      | in_valid, in_ready   | candidate_value [VALUE_WIDTH-1:0]
// out     | out_valid, out_ready | is_prime
//
// One candidate at a time; in_ready is high only while the sequencer is idle.
// Each divisor tried takes its bound check, VALUE_WIDTH restoring-division steps
// in the single remainder unit and the done pulse.
// Divisors run from 2 while d*d <= candidate: at most about 2^(VALUE_WIDTH/2).
// A 16-bit prime such as 65521 tries 254 divisors; 0 to 3 need no division.
// A waiting result holds the sequencer in its last state. Reset clears the
// sequencer and the result flag; no clearing pass.
module trial_division_prime_test import tdpt_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] candidate_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   is_prime
);

	localparam int unsigned SW = VALUE_WIDTH + 2;

	state_t                 state_q;
	state_t                 state_d;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [SW-1:0]          sq_q;
	logic                   prime_q;
	logic                   out_valid_q;
	logic                   is_prime_q;
	rem_stat_t              stat;

	logic too_small;
	logic past_root;
	logic slot_free;
	logic div_start;
	logic advance;
	logic verdict_set;
	logic verdict_val;
	logic res_load;

	assign too_small = (n_q < VALUE_WIDTH'(2));
	assign past_root = (sq_q > {2'b00, n_q});
	assign slot_free = !out_valid_q || out_ready;

	tdpt_rem_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (too_small || past_root) state_d = ST_RESULT;
				else state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (stat.done) state_d = stat.zero ? ST_RESULT : ST_CHECK;
			end
			ST_RESULT: begin
				if (slot_free) state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		div_start   = 1'b0;
		advance     = 1'b0;
		verdict_set = 1'b0;
		verdict_val = 1'b0;
		res_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CHECK: begin
				if (too_small) begin
					verdict_set = 1'b1;
				end else if (past_root) begin
					verdict_set = 1'b1;
					verdict_val = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_DIVIDE: begin
				if (stat.done) begin
					verdict_set = stat.zero;
					advance     = !stat.zero;
				end
			end
			ST_RESULT: begin
				res_load = slot_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			n_q  <= candidate_value;
			d_q  <= VALUE_WIDTH'(2);
			sq_q <= SW'(4);
		end else if (advance) begin
			d_q  <= d_q + VALUE_WIDTH'(1);
			sq_q <= sq_q + SW'({d_q, 1'b1});
		end
		if (verdict_set) prime_q <= verdict_val;
		if (res_load) is_prime_q <= prime_q;
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

endmodule

### src/trial_division_prime_test_checker.sv
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test_checker import tdpt_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [VALUE_WIDTH-1:0] candidate_value,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   is_prime
);

	logic in_fire;
	logic cand_seen;

	assign in_fire   = in_valid && in_ready;
	assign cand_seen = ^candidate_value || !(^candidate_value);

	`TDPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_prime), "result dropped or changed while stalled")
	`TDPT_ASSERT_NEXT(a_busy_after_accept, in_fire && cand_seen, !in_ready, "ready after a transaction was accepted")
	`TDPT_ASSERT_NEXT(a_no_instant_result, in_fire, !$rose(out_valid), "result appeared one cycle after accept")
	`TDPT_ASSERT_NOW(a_idle_on_result, $rose(out_valid), in_ready, "result loaded while sequencer busy")

endmodule

bind trial_division_prime_test trial_division_prime_test_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import tdpt_pkg::*;

	localparam int unsigned W = VALUE_WIDTH_DEF;
	localparam int STALL_LIMIT = 30000;
	localparam int HOLD_CYCLES = 1000;
	localparam int RANDOM_ITEMS = 75;
	localparam int QUIET_ITEMS = 30;
	localparam int DIRECTED_ROWS = 19;

	typedef struct packed {
		logic [W-1:0] value;
		bit           known;
		bit           prime;
	} vector_t;

	typedef struct packed {
		logic [W-1:0] value;
		bit           prime;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [W-1:0] candidate_value = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic         is_prime;

	verdict_t verdict_q[$];
	int       error_count = 0;
	int       stall_cycles = 0;
	bit       quiet = 1'b0;
	bit       hold_request = 1'b0;

	vector_t directed [DIRECTED_ROWS] = '{
		'{16'd0,     1'b1, 1'b0},
		'{16'd1,     1'b1, 1'b0},
		'{16'd2,     1'b1, 1'b1},
		'{16'd3,     1'b1, 1'b1},
		'{16'd4,     1'b1, 1'b0},
		'{16'd65535, 1'b1, 1'b0},
		'{16'd65534, 1'b1, 1'b0},
		'{16'd65521, 1'b1, 1'b1},
		'{16'd32768, 1'b1, 1'b0},
		'{16'd5,     1'b0, 1'b0},
		'{16'd9,     1'b0, 1'b0},
		'{16'd25,    1'b0, 1'b0},
		'{16'd49,    1'b0, 1'b0},
		'{16'd4093,  1'b0, 1'b0},
		'{16'd63001, 1'b0, 1'b0},
		'{16'd65025, 1'b0, 1'b0},
		'{16'd21845, 1'b0, 1'b0},
		'{16'd43691, 1'b0, 1'b0},
		'{16'd32767, 1'b0, 1'b0}
	};

	trial_division_prime_test #(
		.VALUE_WIDTH(W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.candidate_value(candidate_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.is_prime       (is_prime)
	);

	always #4 clk = ~clk;

	function automatic bit prime_by_division(logic [W-1:0] n);
		int unsigned d;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic offer(logic [W-1:0] value, bit prime);
		verdict_t v;
		int gap;
		if (!quiet && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		candidate_value <= value;
		do @(posedge clk); while (!in_ready);
		v.value = value;
		v.prime = prime;
		verdict_q.push_back(v);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (verdict_q.size() == 0);
		@(negedge clk);
	endtask

	initial begin
		int n;
		int pick;
		logic [W-1:0] value;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[k])
			offer(directed[k].value,
				directed[k].known ? directed[k].prime : prime_by_division(directed[k].value));
		drain();

		// hold the receiver while candidates keep coming
		hold_request = 1'b1;
		for (n = 0; n < 6; n++) begin
			value = W'($urandom_range(255));
			offer(value, prime_by_division(value));
		end
		drain();

		quiet = 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == QUIET_ITEMS)
				quiet = 1'b0;
			pick = $urandom_range(99);
			if (pick < 60)
				value = W'($urandom_range(255));
			else if (pick < 85)
				value = W'($urandom_range(4095));
			else
				value = W'($urandom_range(65535));
			offer(value, prime_by_division(value));
		end
		drain();
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("PASS trial_division_prime_test");
		end else begin
			$display("FAIL trial_division_prime_test");
		end
		$finish;
	end

	initial begin
		int held;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_request = 1'b0;
			end
			out_ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected transaction: is_prime %0b with no candidate pending", is_prime);
				error_count++;
			end else begin
				v = verdict_q.pop_front();
				if (is_prime !== v.prime) begin
					$error("is_prime mismatch for %0d: expected %0b, actual %0b",
						v.value, v.prime, is_prime);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL trial_division_prime_test");
			$finish;
		end
	end

endmodule

### trial_division_prime_test.f
+incdir+src
src/tdpt_pkg.sv
src/tdpt_rem_unit.sv
src/trial_division_prime_test.sv
src/trial_division_prime_test_checker.sv
tb/tb.sv
